>>> rtl/core/assert_macros.svh
// Assertion helpers; clk and rst must be in scope where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define KMS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define KMS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> rtl/core/kms_pkg.sv
`timescale 1ns / 1ps

package kms_pkg;

  localparam int OUT_SLOTS = 6;

  localparam logic [7:0] MOD_FIRST = 8'hE0;
  localparam logic [7:0] MOD_LAST  = 8'hE7;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } op_t;

  typedef enum logic {
    REG_LAYER_KEY_LOW  = 1'b0,
    REG_LAYER_KEY_HIGH = 1'b1
  } reg_index_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] column;
    logic [3:0] row_levels;
    logic [1:0] layer;
    logic [5:0] key_index;
    logic [7:0] code;
  } scan_item_t;

  typedef struct packed {
    logic [7:0] modifiers;
    logic [7:0] slot0;
    logic [7:0] slot1;
    logic [7:0] slot2;
    logic [7:0] slot3;
    logic [7:0] slot4;
    logic [7:0] slot5;
    logic [5:0] change_count;
  } hid_report_t;

  // One key of the report walk, as it comes out of the memories.
  typedef struct packed {
    logic       valid;
    logic       pressed;
    logic [7:0] base;
    logic [7:0] code;
  } key_event_t;

  typedef logic [OUT_SLOTS-1:0][7:0] slot_array_t;

endpackage

>>> rtl/core/key_matrix_scan_hid_report.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall    kms_pkg::scan_item_t in_data
// out      output     out_valid / out_stall  kms_pkg::hid_report_t out_data
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load is written in place; a column scan reads the pressed map, then writes it back.
// The last column, if any key changed, adds a report walk: one pressed
// map read per column to find the layer keys, then one code table read per key.
// Reset clears the pressed map valid bits, change counter, state and config registers; code tables are not cleared.
// A finished report waits only if the previous one is still held by out_stall.

module key_matrix_scan_hid_report #(
  parameter int ROWS         = 4,
  parameter int COLS         = 14,
  parameter int LAYERS       = 4,
  parameter int REPORT_SLOTS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kms_pkg::scan_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kms_pkg::hid_report_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  kms_pkg::reg_index_t  cfg_index,
  input  logic [5:0]           cfg_data
);

  `include "assert_macros.svh"

  localparam int KEYS    = ROWS * COLS;
  localparam int ENTRIES = LAYERS * KEYS;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int KEY_W   = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int CODE_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CMP_W   = KEY_W + 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAYER,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t state;

  logic [5:0]       layer_key_low;
  logic [5:0]       layer_key_high;
  logic [5:0]       scan_changes;
  logic [COL_W-1:0] scan_col;
  logic [3:0]       scan_levels;
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [KEY_W-1:0] key_cnt;
  logic             iss_done;
  logic             p_valid;
  logic [KEY_W-1:0] p_base;
  logic [ROW_W-1:0] p_row;
  logic             lk_lo;
  logic             lk_hi;
  logic [1:0]       layer_sel;

  // pressed map, one row word per column
  logic [ROWS-1:0]  pressed_mem [COLS];
  logic [COLS-1:0]  col_valid;
  logic [ROWS-1:0]  pressed_rd;
  logic             pressed_ok;

  // layer-0 codes are kept twice so the walk reads base and active code together
  logic [7:0]       base_mem [KEYS];
  logic [7:0]       code_mem [ENTRIES];
  logic [7:0]       base_rd;
  logic [7:0]       code_rd;

  logic              accept;
  logic              load_ok;
  logic              scan_go;
  logic [COL_W-1:0]  pressed_addr;
  logic [CODE_W-1:0] load_addr;
  logic [CODE_W-1:0] code_addr;
  logic [ROWS-1:0]   pdata;
  logic [15:0]       levels_ext;
  logic [ROWS-1:0]   scan_now;
  logic [4:0]        flips;
  logic [6:0]        change_sum;
  logic [5:0]        changes_next;
  logic              last_col;
  logic [CMP_W-1:0]  lo_off;
  logic [CMP_W-1:0]  hi_off;
  logic              lo_hit;
  logic              hi_hit;
  logic [ROWS-1:0]   lo_shift;
  logic [ROWS-1:0]   hi_shift;
  logic [1:0]        layer_raw;
  logic [1:0]        layer_pick;
  logic              slot_clear;
  logic              finish_go;

  kms_pkg::key_event_t  ev;
  logic [7:0]           fill_mods;
  kms_pkg::slot_array_t fill_slots;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    accept  = in_valid && !in_stall;
    load_ok = accept && (in_data.op == kms_pkg::OP_LOAD) &&
              (32'(in_data.layer) < LAYERS) && (32'(in_data.key_index) < KEYS);
    scan_go = accept && (in_data.op == kms_pkg::OP_SCAN) && (32'(in_data.column) < COLS);

    pressed_addr = (state == ST_IDLE) ? COL_W'(in_data.column) : col_cnt;
    load_addr    = CODE_W'(CODE_W'(in_data.layer) * CODE_W'(KEYS)) +
                   CODE_W'(in_data.key_index);
    code_addr    = CODE_W'(CODE_W'(layer_sel) * CODE_W'(KEYS)) + CODE_W'(key_cnt);

    pdata = pressed_ok ? pressed_rd : '0;

    // rows above the level field read as released
    levels_ext = {12'hFFF, scan_levels};
    for (int r = 0; r < ROWS; r++) begin
      scan_now[r] = ~levels_ext[r];
    end
    flips        = 5'($countones(pdata ^ scan_now));
    change_sum   = 7'(scan_changes) + 7'(flips);
    changes_next = (change_sum > 7'd63) ? 6'd63 : change_sum[5:0];
    last_col     = (scan_col == COL_W'(COLS - 1));

    // layer key lookup against the column whose first key index is p_base
    lo_off   = CMP_W'(layer_key_low) - CMP_W'(p_base);
    hi_off   = CMP_W'(layer_key_high) - CMP_W'(p_base);
    lo_hit   = (CMP_W'(layer_key_low) >= CMP_W'(p_base)) && (lo_off < CMP_W'(ROWS));
    hi_hit   = (CMP_W'(layer_key_high) >= CMP_W'(p_base)) && (hi_off < CMP_W'(ROWS));
    lo_shift = pdata >> lo_off;
    hi_shift = pdata >> hi_off;

    layer_raw  = {lk_hi, lk_lo};
    layer_pick = (32'(layer_raw) < LAYERS) ? layer_raw : 2'd0;

    slot_clear = (state == ST_LAYER) && iss_done && !p_valid;
    finish_go  = (state == ST_FINISH) && (!out_valid || !out_stall);

    ev.valid   = p_valid && (state == ST_WALK);
    ev.pressed = pdata[p_row];
    ev.base    = base_rd;
    ev.code    = code_rd;
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      pressed_mem[scan_col] <= scan_now;
    end
    pressed_rd <= pressed_mem[pressed_addr];
    pressed_ok <= col_valid[pressed_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= '0;
    end else if (state == ST_SCAN) begin
      col_valid[scan_col] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      code_mem[load_addr] <= in_data.code;
      if (in_data.layer == 2'd0) begin
        base_mem[KEY_W'(in_data.key_index)] <= in_data.code;
      end
    end
    base_rd <= base_mem[key_cnt];
    code_rd <= code_mem[code_addr];
  end

  kms_slot_fill #(
    .REPORT_SLOTS(REPORT_SLOTS)
  ) u_slot_fill (
    .clk      (clk),
    .rst      (rst),
    .clear    (slot_clear),
    .ev       (ev),
    .modifiers(fill_mods),
    .slots    (fill_slots)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      scan_changes   <= '0;
      out_valid      <= 1'b0;
      layer_key_low  <= 6'd0;
      layer_key_high <= 6'd1;
      iss_done       <= 1'b0;
      p_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kms_pkg::REG_LAYER_KEY_LOW:  layer_key_low  <= cfg_data;
          kms_pkg::REG_LAYER_KEY_HIGH: layer_key_high <= cfg_data;
          default: ;
        endcase
      end

      // a report leaving while the next one is ready is replaced in ST_FINISH
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (scan_go) begin
            scan_col    <= COL_W'(in_data.column);
            scan_levels <= in_data.row_levels;
            state       <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          scan_changes <= changes_next;
          if (last_col && (changes_next != 6'd0)) begin
            col_cnt  <= '0;
            key_cnt  <= '0;
            iss_done <= 1'b0;
            p_valid  <= 1'b0;
            lk_lo    <= 1'b0;
            lk_hi    <= 1'b0;
            state    <= ST_LAYER;
          end else begin
            state <= ST_IDLE;
          end
        end

        ST_LAYER: begin
          p_valid <= !iss_done;
          if (!iss_done) begin
            p_base  <= key_cnt;
            col_cnt <= col_cnt + COL_W'(1);
            key_cnt <= key_cnt + KEY_W'(ROWS);
            if (col_cnt == COL_W'(COLS - 1)) begin
              iss_done <= 1'b1;
            end
          end
          if (p_valid) begin
            if (lo_hit) begin
              lk_lo <= lo_shift[0];
            end
            if (hi_hit) begin
              lk_hi <= hi_shift[0];
            end
          end
          if (iss_done && !p_valid) begin
            layer_sel <= layer_pick;
            col_cnt   <= '0;
            row_cnt   <= '0;
            key_cnt   <= '0;
            iss_done  <= 1'b0;
            state     <= ST_WALK;
          end
        end

        ST_WALK: begin
          p_valid <= !iss_done;
          if (!iss_done) begin
            p_row   <= row_cnt;
            key_cnt <= key_cnt + KEY_W'(1);
            if (row_cnt == ROW_W'(ROWS - 1)) begin
              row_cnt <= '0;
              col_cnt <= col_cnt + COL_W'(1);
            end else begin
              row_cnt <= row_cnt + ROW_W'(1);
            end
            if (key_cnt == KEY_W'(KEYS - 1)) begin
              iss_done <= 1'b1;
            end
          end
          if (iss_done && !p_valid) begin
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid             <= 1'b1;
            out_data.modifiers    <= fill_mods;
            out_data.slot0        <= fill_slots[0];
            out_data.slot1        <= fill_slots[1];
            out_data.slot2        <= fill_slots[2];
            out_data.slot3        <= fill_slots[3];
            out_data.slot4        <= fill_slots[4];
            out_data.slot5        <= fill_slots[5];
            out_data.change_count <= scan_changes;
            scan_changes          <= '0;
            state                 <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  `KMS_ASSERT(a_report_has_changes, out_valid |-> out_data.change_count != 6'd0)
  `KMS_ASSERT(a_scan_follows_accept, scan_go |=> state == ST_SCAN)
  `KMS_ASSERT(a_finish_clears, finish_go |=> out_valid && scan_changes == 6'd0 && state == ST_IDLE)
  `KMS_ASSERT(a_walk_drained, (state == ST_FINISH) |-> !p_valid)

endmodule

>>> rtl/core/kms_slot_fill.sv
`timescale 1ns / 1ps

module kms_slot_fill #(
  parameter int REPORT_SLOTS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  kms_pkg::key_event_t  ev,
  output logic [7:0]           modifiers,
  output kms_pkg::slot_array_t slots
);

  localparam int USED_W = $clog2(kms_pkg::OUT_SLOTS + 1);

  logic [USED_W-1:0] used;
  logic              is_mod;

  always_comb begin
    is_mod = ev.base inside {[kms_pkg::MOD_FIRST:kms_pkg::MOD_LAST]};
  end

  // Modifier keys are classified by their layer-0 code; the rest fill slots in key order.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      used      <= '0;
      modifiers <= '0;
      slots     <= '0;
    end else if (ev.valid && ev.pressed) begin
      if (is_mod) begin
        modifiers[ev.base[2:0]] <= 1'b1;
      end else if (32'(used) < REPORT_SLOTS) begin
        slots[used] <= ev.code;
        used        <= used + USED_W'(1);
      end
    end
  end

endmodule
